[rtl/fcs_pkg.sv]
package fcs_pkg;

    // Field widths
    localparam int CODE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int TICK_W  = 8;
    localparam int PHASE_W = 2;
    localparam int MSG_W   = 4;
    localparam int VEL_W   = 17;
    localparam int EXP_W   = 26;
    localparam int ELAP_W  = 32;
    localparam int CFG_IDX_W = 2;

    // Packed stream widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 88;

    // Command codes
    localparam logic [CODE_W-1:0] CMD_IDLE       = 8'h00;
    localparam logic [CODE_W-1:0] CMD_TAKEOFF    = 8'h01;
    localparam logic [CODE_W-1:0] CMD_LAND       = 8'h02;
    localparam logic [CODE_W-1:0] CMD_UP         = 8'h03;
    localparam logic [CODE_W-1:0] CMD_DOWN       = 8'h04;
    localparam logic [CODE_W-1:0] CMD_FORWARD    = 8'h05;
    localparam logic [CODE_W-1:0] CMD_BACK       = 8'h06;
    localparam logic [CODE_W-1:0] CMD_LEFT       = 8'h07;
    localparam logic [CODE_W-1:0] CMD_RIGHT      = 8'h08;
    localparam logic [CODE_W-1:0] CMD_TURN_LEFT  = 8'h09;
    localparam logic [CODE_W-1:0] CMD_TURN_RIGHT = 8'h0A;
    localparam logic [CODE_W-1:0] CMD_STOP       = 8'hA0;

    // Message codes
    localparam logic [MSG_W-1:0] MSG_NONE        = 4'd0;
    localparam logic [MSG_W-1:0] MSG_STATE_ERR   = 4'd1;
    localparam logic [MSG_W-1:0] MSG_TAKEOFF     = 4'd2;
    localparam logic [MSG_W-1:0] MSG_TAKEOFF_OK  = 4'd3;
    localparam logic [MSG_W-1:0] MSG_CMD_ERR     = 4'd4;
    localparam logic [MSG_W-1:0] MSG_LANDING     = 4'd5;
    localparam logic [MSG_W-1:0] MSG_LANDED      = 4'd6;
    localparam logic [MSG_W-1:0] MSG_STOPPED     = 4'd7;
    localparam logic [MSG_W-1:0] MSG_MOVE_START  = 4'd8;
    localparam logic [MSG_W-1:0] MSG_MOVE_DONE   = 4'd9;

    // Take-off phases
    localparam logic [PHASE_W-1:0] PHASE_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_FINISHED = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_BEYOND   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIMB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN    = 2'd3;

    // Configuration reset values
    localparam logic [WORD_W-1:0] CLIMB_RST   = 16'd200;
    localparam logic [WORD_W-1:0] DESCENT_RST = 16'd150;
    localparam logic [WORD_W-1:0] HORIZ_RST   = 16'd300;
    localparam logic [WORD_W-1:0] TURN_RST    = 16'd90;

    // Input selector on tuser
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [EXP_W-1:0] MS_PER_S = 26'd1000;

    // Axis of a move
    typedef enum logic [1:0] {
        AXIS_X   = 2'd0,
        AXIS_Y   = 2'd1,
        AXIS_Z   = 2'd2,
        AXIS_YAW = 2'd3
    } t_axis;

endpackage

[rtl/flight_command_sequencer.sv]
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+------------------------------------------
// s stream  | in  | i_s_tvalid/o_s_tready  | i_s_tdata, i_s_tuser = operation
// m stream  | out | o_m_tvalid/i_m_tready  | o_m_tdata
// cfg write | in  | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
// A command frame is stored and gives no result.
// A timer tick is loaded at its accept edge, then runs 26 steps of the restoring
// divider (move time = amount*1000 / divisor) and a finish state: its result is
// registered when the finish state completes, and the input is then ready again.
// The input is not ready from accept until the finish cycle has completed.
// The finish cycle waits while the previous result is still held on the output.
// Synchronous active-low reset clears the sequencer state and output valid and loads the limit defaults.
module flight_command_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // cfg port
    input  logic                          i_cfg_we,
    input  logic [fcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fcs_pkg::WORD_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] command, [23:8] amount, [39:24] speed, [47:40] tick_ms, [48] link_lost,
    // [49] position_hold_mode, [50] position_source_ok, [52:51] takeoff_phase,
    // [53] motors_unlocked, [55:54] zero
    input  logic [fcs_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] operation
    input  logic                          i_s_tuser,
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] active_command, [11:8] message, [12] request_takeoff, [13] request_land,
    // [14] request_lock, [31:15] velocity_x, [48:32] velocity_y, [65:49] velocity_z,
    // [82:66] yaw_rate, [87:83] zero
    output logic [fcs_pkg::M_DATA_W-1:0]  o_m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int CNT_W = $clog2(fcs_pkg::EXP_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(fcs_pkg::EXP_W - 1);

    // Input field unpack
    logic [fcs_pkg::CODE_W-1:0]  s_command;
    logic [fcs_pkg::WORD_W-1:0]  s_amount;
    logic [fcs_pkg::WORD_W-1:0]  s_speed;
    logic [fcs_pkg::TICK_W-1:0]  s_tick;
    logic                        s_link_lost;
    logic                        s_hold;
    logic                        s_src_ok;
    logic [fcs_pkg::PHASE_W-1:0] s_phase;
    logic                        s_motors;

    assign s_command   = i_s_tdata[7:0];
    assign s_amount    = i_s_tdata[23:8];
    assign s_speed     = i_s_tdata[39:24];
    assign s_tick      = i_s_tdata[47:40];
    assign s_link_lost = i_s_tdata[48];
    assign s_hold      = i_s_tdata[49];
    assign s_src_ok    = i_s_tdata[50];
    assign s_phase     = i_s_tdata[52:51];
    assign s_motors    = i_s_tdata[53];

    // Registers
    logic [1:0]                  r_state;
    logic [fcs_pkg::WORD_W-1:0]  r_lim_climb, r_lim_descent, r_lim_horiz, r_lim_turn;
    logic [fcs_pkg::CODE_W-1:0]  r_code, r_prev;
    logic                        r_ready_flag, r_takeoff_sent, r_state_err;
    logic [fcs_pkg::WORD_W-1:0]  r_amount, r_speed;
    logic [fcs_pkg::ELAP_W-1:0]  r_elapsed;
    logic [fcs_pkg::TICK_W-1:0]  r_tick;
    logic [fcs_pkg::PHASE_W-1:0] r_phase;
    logic                        r_motors;
    logic [fcs_pkg::WORD_W-1:0]  r_div;
    logic [fcs_pkg::WORD_W-1:0]  r_rem;
    logic [fcs_pkg::EXP_W-1:0]   r_quo;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_m_valid;
    logic [fcs_pkg::M_DATA_W-1:0] r_m_data;

    logic s_accept, tick_accept, frame_accept, out_free;
    assign o_s_tready   = (r_state == ST_IDLE);
    assign s_accept     = i_s_tvalid && o_s_tready;
    assign tick_accept  = s_accept && (i_s_tuser == fcs_pkg::OP_TICK);
    assign frame_accept = s_accept && (i_s_tuser == fcs_pkg::OP_FRAME);
    assign out_free     = !r_m_valid || i_m_tready;

    // Code change check at tick accept
    logic                       changed, link_ok;
    logic [fcs_pkg::CODE_W-1:0] chk_code;
    assign changed  = (r_code != r_prev);
    assign link_ok  = !s_link_lost && s_hold && s_src_ok;
    assign chk_code = (changed && !link_ok) ? fcs_pkg::CMD_IDLE : r_code;

    // Divisor: held speed clamped to the axis limit of the checked code
    logic [fcs_pkg::WORD_W-1:0] axis_lim, div_sel;
    always_comb begin
        unique case (chk_code)
            fcs_pkg::CMD_UP:    axis_lim = r_lim_climb;
            fcs_pkg::CMD_DOWN:  axis_lim = r_lim_descent;
            fcs_pkg::CMD_TURN_LEFT,
            fcs_pkg::CMD_TURN_RIGHT: axis_lim = r_lim_turn;
            default:            axis_lim = r_lim_horiz;
        endcase
        div_sel = (r_speed < axis_lim) ? r_speed : axis_lim;
    end

    logic [fcs_pkg::EXP_W-1:0] dividend;
    assign dividend = fcs_pkg::EXP_W'(r_amount) * fcs_pkg::MS_PER_S;

    // Restoring divider step
    logic [fcs_pkg::WORD_W:0]   rem_sh;
    logic [fcs_pkg::WORD_W-1:0] rem_sub;
    logic                       rem_ge;
    assign rem_sh  = {r_rem, r_quo[fcs_pkg::EXP_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh[fcs_pkg::WORD_W-1:0] - r_div;

    // Finish cycle: command sequencing
    logic [fcs_pkg::EXP_W-1:0]  expected;
    logic                       is_move, move_neg;
    fcs_pkg::t_axis             move_axis;
    logic [fcs_pkg::CODE_W-1:0] fin_code;
    logic [fcs_pkg::MSG_W-1:0]  fin_msg;
    logic                       req_to, req_land, req_lock, set_sent;
    logic [fcs_pkg::ELAP_W-1:0] elap_sum;
    logic                       elap_ovf;

    assign expected = (r_div == '0) ? '0 : r_quo;
    assign {elap_ovf, elap_sum} = {1'b0, r_elapsed} + (fcs_pkg::ELAP_W + 1)'(r_tick);

    always_comb begin
        is_move   = 1'b1;
        move_neg  = 1'b0;
        move_axis = fcs_pkg::AXIS_X;
        unique case (r_code)
            fcs_pkg::CMD_UP:         move_axis = fcs_pkg::AXIS_Z;
            fcs_pkg::CMD_DOWN: begin
                move_axis = fcs_pkg::AXIS_Z;
                move_neg  = 1'b1;
            end
            fcs_pkg::CMD_FORWARD:    move_axis = fcs_pkg::AXIS_X;
            fcs_pkg::CMD_BACK:       move_neg  = 1'b1;
            fcs_pkg::CMD_LEFT:       move_axis = fcs_pkg::AXIS_Y;
            fcs_pkg::CMD_RIGHT: begin
                move_axis = fcs_pkg::AXIS_Y;
                move_neg  = 1'b1;
            end
            fcs_pkg::CMD_TURN_LEFT:  move_axis = fcs_pkg::AXIS_YAW;
            fcs_pkg::CMD_TURN_RIGHT: begin
                move_axis = fcs_pkg::AXIS_YAW;
                move_neg  = 1'b1;
            end
            default:                 is_move = 1'b0;
        endcase
    end

    always_comb begin
        fin_code = r_code;
        fin_msg  = r_state_err ? fcs_pkg::MSG_STATE_ERR : fcs_pkg::MSG_NONE;
        req_to   = 1'b0;
        req_land = 1'b0;
        req_lock = 1'b0;
        set_sent = 1'b0;
        if (r_code == fcs_pkg::CMD_TAKEOFF) begin
            if (r_ready_flag) begin
                // take-off still running: nothing to report
                if (r_phase == fcs_pkg::PHASE_IDLE) begin
                    if (!r_takeoff_sent) begin
                        set_sent = 1'b1;
                        fin_msg  = fcs_pkg::MSG_TAKEOFF;
                        req_to   = 1'b1;
                    end
                end else if (r_phase == fcs_pkg::PHASE_FINISHED) begin
                    fin_msg  = fcs_pkg::MSG_TAKEOFF_OK;
                    fin_code = fcs_pkg::CMD_IDLE;
                end else if (r_phase == fcs_pkg::PHASE_BEYOND) begin
                    fin_msg  = fcs_pkg::MSG_CMD_ERR;
                    fin_code = fcs_pkg::CMD_IDLE;
                end
            end
        end else if (r_code == fcs_pkg::CMD_LAND) begin
            if (r_phase == fcs_pkg::PHASE_FINISHED) begin
                fin_msg  = fcs_pkg::MSG_LANDING;
                req_land = 1'b1;
            end else if (r_phase == fcs_pkg::PHASE_IDLE) begin
                fin_msg  = fcs_pkg::MSG_LANDED;
                fin_code = fcs_pkg::CMD_IDLE;
            end
        end else if (r_code == fcs_pkg::CMD_STOP) begin
            if (r_motors) begin
                fin_msg  = fcs_pkg::MSG_STOPPED;
                req_lock = 1'b1;
                fin_code = fcs_pkg::CMD_IDLE;
            end
        end else if (is_move) begin
            if (r_elapsed == '0) begin
                fin_msg = fcs_pkg::MSG_MOVE_START;
            end else if ({{(fcs_pkg::ELAP_W - fcs_pkg::EXP_W){1'b0}}, expected} < r_elapsed)
            begin
                fin_msg  = fcs_pkg::MSG_MOVE_DONE;
                fin_code = fcs_pkg::CMD_IDLE;
            end
        end
    end

    // Velocity references: only the axis of a move still running is nonzero
    logic signed [fcs_pkg::VEL_W-1:0] vel_mag, vel_val;
    logic signed [fcs_pkg::VEL_W-1:0] vel_x, vel_y, vel_z, vel_yaw;
    logic                             vel_on;
    assign vel_mag = {1'b0, r_speed};
    assign vel_val = move_neg ? -vel_mag : vel_mag;
    assign vel_on  = is_move && (fin_code != fcs_pkg::CMD_IDLE);
    assign vel_x   = (vel_on && move_axis == fcs_pkg::AXIS_X)   ? vel_val : '0;
    assign vel_y   = (vel_on && move_axis == fcs_pkg::AXIS_Y)   ? vel_val : '0;
    assign vel_z   = (vel_on && move_axis == fcs_pkg::AXIS_Z)   ? vel_val : '0;
    assign vel_yaw = (vel_on && move_axis == fcs_pkg::AXIS_YAW) ? vel_val : '0;

    logic fin_go;
    assign fin_go = (r_state == ST_FIN) && out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_climb   <= fcs_pkg::CLIMB_RST;
            r_lim_descent <= fcs_pkg::DESCENT_RST;
            r_lim_horiz   <= fcs_pkg::HORIZ_RST;
            r_lim_turn    <= fcs_pkg::TURN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fcs_pkg::REG_CLIMB:   r_lim_climb   <= i_cfg_wdata;
                fcs_pkg::REG_DESCENT: r_lim_descent <= i_cfg_wdata;
                fcs_pkg::REG_HORIZ:   r_lim_horiz   <= i_cfg_wdata;
                fcs_pkg::REG_TURN:    r_lim_turn    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and command state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_code         <= fcs_pkg::CMD_IDLE;
            r_prev         <= fcs_pkg::CMD_IDLE;
            r_ready_flag   <= 1'b0;
            r_takeoff_sent <= 1'b0;
            r_state_err    <= 1'b0;
            r_amount       <= '0;
            r_speed        <= '0;
            r_elapsed      <= '0;
            r_cnt          <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (frame_accept) begin
                        r_code   <= s_command;
                        r_amount <= s_amount;
                        r_speed  <= s_speed;
                    end else if (tick_accept) begin
                        r_code      <= chk_code;
                        r_state_err <= changed && !link_ok;
                        if (changed) begin
                            r_takeoff_sent <= 1'b0;
                            r_elapsed      <= '0;
                            r_ready_flag   <= link_ok;
                        end
                        r_cnt   <= CNT_LAST;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_code <= fin_code;
                        r_prev <= fin_code;
                        if (fin_code == fcs_pkg::CMD_IDLE) begin
                            r_takeoff_sent <= 1'b0;
                            r_elapsed      <= '0;
                        end else begin
                            if (set_sent) begin
                                r_takeoff_sent <= 1'b1;
                            end
                            if (is_move) begin
                                r_elapsed <= elap_ovf ? '1 : elap_sum;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Tick operands and divider datapath
    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_tick   <= s_tick;
            r_phase  <= s_phase;
            r_motors <= s_motors;
            r_div    <= div_sel;
            r_rem    <= '0;
            r_quo    <= dividend;
        end else if (r_state == ST_DIV) begin
            r_rem <= rem_ge ? rem_sub : rem_sh[fcs_pkg::WORD_W-1:0];
            r_quo <= {r_quo[fcs_pkg::EXP_W-2:0], rem_ge};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (fin_go) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_m_data <= {5'b0, vel_yaw, vel_z, vel_y, vel_x,
                         req_lock, req_land, req_to, fin_msg, fin_code};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule
